// ===== rtl/core/srs_pkg.sv =====
// Package with shared constants for the speed ramp smoother.
package srs_pkg;

   localparam int unsigned SPEED_W    = 16;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned INTERVAL_W = 16;

   // Division by five: x / 5 == (x * 52429) >> 18 for every 16-bit x.
   localparam logic [SPEED_W-1:0] DIV5_RECIP = 16'd52429;
   localparam int unsigned        DIV5_SHIFT = 18;
   localparam int unsigned        PROD_W     = 2 * SPEED_W;

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd100;

   typedef enum logic {
      OP_SET_TARGET = 1'b0,
      OP_TICK       = 1'b1
   } op_type;

endpackage

// ===== rtl/core/speed_ramp_smoother_unit.sv =====
// Top level of the speed ramp smoother: input register, update logic, result register.
//
// Usage:
//   The request channel (req_valid / req_stall) carries one beat per item: req_op selects
//   a new target (req_target_speed) or a time tick (req_now_ms). The response channel
//   (rsp_valid / rsp_stall) returns one beat per item holding the smoothed speed after
//   that item. A beat is taken at a clock edge where valid is high and stall is low.
//   The response beat is registered twice after the request beat is accepted: the
//   accepting edge loads the input register, and the result register is loaded from it
//   at an edge where the result register is empty or its beat is being taken.
//   Throughput is one item per cycle while rsp_stall is low; the whole update for an item,
//   including the divide-by-five done as a reciprocal multiply, sits between those registers.
//   When the receiver stalls, the result register holds its beat and the input register
//   can still take one more beat; req_stall rises only when both are full.
//   The user must write the interval register through csr_we / csr_wdata only while the
//   block is idle; the block itself does not enforce this. Synchronous reset empties both
//   registers, clears target, smoothed value, step and last tick time to zero, and sets the tick interval to 100 ms.
module speed_ramp_smoother_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [15:0] req_target_speed,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_smoothed_speed,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   localparam int unsigned SW = srs_pkg::SPEED_W;
   localparam int unsigned TW = srs_pkg::TIME_W;

   // Input register.
   logic                    in_valid_ff, in_valid_in;
   srs_pkg::op_type         in_op_ff;
   logic [SW-1:0]           in_target_ff;
   logic [TW-1:0]           in_now_ff;

   // Result register.
   logic                    out_valid_ff, out_valid_in;
   logic [SW-1:0]           out_speed_ff;

   // Block state.
   logic [srs_pkg::INTERVAL_W-1:0] interval_ff, interval_in;
   logic [SW-1:0]           target_ff, target_in;
   logic [SW-1:0]           smoothed_ff, smoothed_in;
   logic [SW-1:0]           step_ff, step_in;
   logic [TW-1:0]           last_tick_ff, last_tick_in;

   logic                    advance;
   logic                    process;
   logic                    req_take;

   logic                    below;
   logic [SW-1:0]           gap;
   logic [srs_pkg::PROD_W-1:0] gap_prod;
   logic [SW-1:0]           new_step;
   logic [TW-1:0]           elapsed;
   logic                    tick_due;
   logic [SW:0]             up_sum;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign process   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid          = out_valid_ff;
   assign rsp_smoothed_speed = out_speed_ff;

   // Set-target path: step is one fifth of the distance to the smoothed value.
   always_comb begin
      below    = in_target_ff < smoothed_ff;
      gap      = below ? (smoothed_ff - in_target_ff) : (in_target_ff - smoothed_ff);
      gap_prod = gap * srs_pkg::DIV5_RECIP;
      new_step = SW'(gap_prod >> srs_pkg::DIV5_SHIFT);
   end

   // Tick path.
   always_comb begin
      elapsed  = in_now_ff - last_tick_ff;
      tick_due = elapsed >= TW'(interval_ff);
      up_sum   = {1'b0, smoothed_ff} + {1'b0, step_ff};
   end

   always_comb begin
      target_in    = target_ff;
      smoothed_in  = smoothed_ff;
      step_in      = step_ff;
      last_tick_in = last_tick_ff;
      if (process) begin
         case (in_op_ff)
            srs_pkg::OP_SET_TARGET: begin
               target_in = in_target_ff;
               step_in   = new_step;
               if (below && new_step == '0 && in_target_ff == '0) begin
                  smoothed_in = '0;
               end
            end
            srs_pkg::OP_TICK: begin
               if (tick_due) begin
                  last_tick_in = in_now_ff;
                  if (target_ff <= smoothed_ff) begin
                     // Moving down floors at zero, not at the target.
                     smoothed_in = (smoothed_ff < step_ff) ? '0 : smoothed_ff - step_ff;
                  end else if (up_sum >= {1'b0, target_ff}) begin
                     smoothed_in = target_ff;
                  end else begin
                     smoothed_in = up_sum[SW-1:0];
                  end
               end
            end
            default: begin
               smoothed_in = smoothed_ff;
            end
         endcase
      end
   end

   always_comb begin
      interval_in  = csr_we ? csr_wdata : interval_ff;
      in_valid_in  = req_take ? 1'b1 : (process ? 1'b0 : in_valid_ff);
      out_valid_in = process ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         interval_ff  <= srs_pkg::INTERVAL_RESET;
         target_ff    <= '0;
         smoothed_ff  <= '0;
         step_ff      <= '0;
         last_tick_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         interval_ff  <= interval_in;
         target_ff    <= target_in;
         smoothed_ff  <= smoothed_in;
         step_ff      <= step_in;
         last_tick_ff <= last_tick_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff     <= srs_pkg::op_type'(req_op);
         in_target_ff <= req_target_speed;
         in_now_ff    <= req_now_ms;
      end
      if (process) begin
         out_speed_ff <= smoothed_in;
      end
   end

`ifndef SYNTHESIS
   // Both registers come out of reset empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !in_valid_ff))
      else $error("pipeline not empty after reset");

   // Back pressure reaches the request side only when the input register is full and the result beat is stalled.
   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid && rsp_stall))
      else $error("request stalled with room in the pipeline");

   // While the result beat is held, no item updates the smoothed value.
   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(smoothed_ff))
      else $error("smoothed value changed while result was stalled");
`endif

endmodule
